/* src/mqeb_pkg.sv */
// Shared types and constants for the per-channel event queue block.
// Request/result structs, controller/datapath link structs, kind and status codes.
// No dependencies.
`default_nettype none

package mqeb_pkg;

  // request kinds
  localparam logic [1:0] KIND_REG    = 2'd0;
  localparam logic [1:0] KIND_INJECT = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_BAD_CH  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_NO_FREE = 3'd4;

  // timestamp clock
  localparam logic [19:0] USEC_STEP    = 20'd1000;
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  device;
    logic [15:0] event_type;
    logic [15:0] event_code;
    logic [31:0] event_value;
  } mqeb_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  assigned_device;
    logic [15:0] out_type;
    logic [15:0] out_code;
    logic [31:0] out_value;
    logic [31:0] out_seconds;
    logic [19:0] out_microseconds;
  } mqeb_res_t;

  // one stored event
  typedef struct packed {
    logic [15:0] ev_type;
    logic [15:0] ev_code;
    logic [31:0] ev_value;
    logic [31:0] seconds;
    logic [19:0] microseconds;
  } mqeb_entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // latch the accepted request
    logic exec;     // evaluate and commit the request
    logic rd_done;  // queue memory data is back, form the read result
  } mqeb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rd_hit;   // current request is a read that dequeues an event
  } mqeb_sts_t;

endpackage

`default_nettype wire

/* src/multi_queue_event_buffer_top.sv */
// The result strobe is registered: it follows the execute state, or for a read
// that dequeues an event the memory read state (registered queue memory read).
// The block takes no new request until the last one has its result, as set by
// the execute step and the single queue memory port. The receiver cannot stall.
// Reset (rst_n, synchronous, active low) frees all channels, clears pointers and
// the timestamp clock; queue memory contents are not cleared and need no sweep.
`default_nettype none

module multi_queue_event_buffer_top #(
  parameter int CHANNEL_COUNT = 8,
  parameter int QUEUE_DEPTH   = 256
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire mqeb_pkg::mqeb_req_t in_req,
  output logic                     out_valid,
  output mqeb_pkg::mqeb_res_t      out_res
);
  import mqeb_pkg::*;

  mqeb_cmd_t cmd;
  mqeb_sts_t sts;

  mqeb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  mqeb_dpath #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .QUEUE_DEPTH   (QUEUE_DEPTH)
  ) u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cmd     (cmd),
    .sts     (sts),
    .out_res (out_res)
  );

`ifndef SYNTHESIS
  // an accepted request always takes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not make block busy");

  // results are never on consecutive cycles
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

  // a result only follows a cycle of work
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !busy))
    else $error("result strobe without preceding work");

  // a failed register never reports a channel number
  a_no_free_dev: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status == ST_NO_FREE) |-> (out_res.assigned_device == 3'd0))
    else $error("no-free result carries a channel");
`endif

endmodule

`default_nettype wire

/* src/mqeb_ctrl.sv */
// Controller state machine for the per-channel event queue block.
// Sequences accept, execute and memory read; drives busy and the result strobe.
// Depends on mqeb_pkg.
`default_nettype none

module mqeb_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  output logic                    out_valid,
  output mqeb_pkg::mqeb_cmd_t     cmd,
  input  wire mqeb_pkg::mqeb_sts_t sts
);
  import mqeb_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_MEMRD = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       valid_r, valid_nxt;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.rd_hit) begin
          state_nxt = S_MEMRD;
        end else begin
          state_nxt = S_IDLE;
          valid_nxt = 1'b1;
        end
      end
      S_MEMRD: begin
        state_nxt = S_IDLE;
        valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy        = (state_r != S_IDLE);
  assign out_valid   = valid_r;
  assign cmd.load    = start && (state_r == S_IDLE);
  assign cmd.exec    = (state_r == S_EXEC);
  assign cmd.rd_done = (state_r == S_MEMRD);

endmodule

`default_nettype wire

/* src/mqeb_dpath.sv */
// Datapath for the per-channel event queue block: channel table, ring
// pointers, timestamp clock, queue memory and result register.
// Depends on mqeb_pkg.
`default_nettype none

module mqeb_dpath #(
  parameter int CHANNEL_COUNT = 8,
  parameter int QUEUE_DEPTH   = 256
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mqeb_pkg::mqeb_req_t in_req,
  input  wire mqeb_pkg::mqeb_cmd_t cmd,
  output mqeb_pkg::mqeb_sts_t      sts,
  output mqeb_pkg::mqeb_res_t      out_res
);
  import mqeb_pkg::*;

  localparam int CW        = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int PW        = $clog2(QUEUE_DEPTH);
  localparam int AW        = CW + PW;
  localparam int MEM_DEPTH = 1 << AW;
  localparam int EW        = $bits(mqeb_entry_t);

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    next_ptr = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic mqeb_entry_t mem_entry_cast(input logic [EW-1:0] w);
    mem_entry_cast = mqeb_entry_t'(w);
  endfunction

  mqeb_req_t               req_r;
  logic [CHANNEL_COUNT-1:0] active_r;
  logic [PW-1:0]           wr_ptr_r [CHANNEL_COUNT];
  logic [PW-1:0]           rd_ptr_r [CHANNEL_COUNT];
  logic [31:0]             sec_r;
  logic [19:0]             usec_r;
  logic [31:0]             sec_nxt;
  logic [19:0]             usec_nxt;
  logic [19:0]             usec_sum;

  logic [EW-1:0]           mem [MEM_DEPTH];
  mqeb_entry_t             rd_data_r;
  mqeb_entry_t             wr_entry;
  logic [AW-1:0]           mem_addr;
  logic                    mem_we;
  logic                    mem_re;

  mqeb_res_t               res_r;
  mqeb_res_t               res_nxt;

  logic [CW-1:0]           dev_idx;
  logic                    dev_ok;
  logic [CW-1:0]           free_idx;
  logic                    free_found;
  logic [PW-1:0]           wp;
  logic [PW-1:0]           rp;
  logic [PW-1:0]           wp_next;
  logic                    q_full;
  logic                    q_empty;
  logic                    do_reg;
  logic                    do_inject;
  logic                    do_read;

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_req;
  end

  assign dev_idx = CW'(req_r.device);
  assign dev_ok  = (32'(req_r.device) < 32'(CHANNEL_COUNT)) && active_r[dev_idx];
  assign wp      = wr_ptr_r[dev_idx];
  assign rp      = rd_ptr_r[dev_idx];
  assign wp_next = next_ptr(wp);
  assign q_full  = (wp_next == rp);
  assign q_empty = (wp == rp);

  // lowest inactive channel
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = CHANNEL_COUNT - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_idx   = CW'(i);
        free_found = 1'b1;
      end
    end
  end

  assign do_reg    = cmd.exec && (req_r.kind == KIND_REG) && free_found;
  assign do_inject = cmd.exec && (req_r.kind == KIND_INJECT) && dev_ok && !q_full;
  assign do_read   = cmd.exec && (req_r.kind == KIND_READ) && dev_ok && !q_empty;

  assign sts.rd_hit = (req_r.kind == KIND_READ) && dev_ok && !q_empty;

  // timestamp advance; usec stays below 2^20 before the wrap compare
  assign usec_sum = usec_r + USEC_STEP;
  always_comb begin
    if (usec_sum >= USEC_PER_SEC) begin
      usec_nxt = usec_sum - USEC_PER_SEC;
      sec_nxt  = sec_r + 32'd1;
    end else begin
      usec_nxt = usec_sum;
      sec_nxt  = sec_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      sec_r    <= '0;
      usec_r   <= '0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        wr_ptr_r[i] <= '0;
        rd_ptr_r[i] <= '0;
      end
    end else begin
      if (do_reg) begin
        active_r[free_idx] <= 1'b1;
        wr_ptr_r[free_idx] <= '0;
        rd_ptr_r[free_idx] <= '0;
      end
      if (do_inject) begin
        wr_ptr_r[dev_idx] <= wp_next;
        sec_r             <= sec_nxt;
        usec_r            <= usec_nxt;
      end
      if (do_read) begin
        rd_ptr_r[dev_idx] <= next_ptr(rp);
      end
    end
  end

  // queue memory: one port, address is channel then slot
  assign mem_addr = do_inject ? {dev_idx, wp} : {dev_idx, rp};
  assign mem_we   = do_inject;
  assign mem_re   = do_read;

  assign wr_entry.ev_type      = req_r.event_type;
  assign wr_entry.ev_code      = req_r.event_code;
  assign wr_entry.ev_value     = req_r.event_value;
  assign wr_entry.seconds      = sec_nxt;
  assign wr_entry.microseconds = usec_nxt;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= wr_entry;
    if (mem_re) rd_data_r <= mem_entry_cast(mem[mem_addr]);
  end

  // result
  always_comb begin
    res_nxt = '0;
    if (cmd.rd_done) begin
      res_nxt.status           = ST_OK;
      res_nxt.out_type         = rd_data_r.ev_type;
      res_nxt.out_code         = rd_data_r.ev_code;
      res_nxt.out_value        = rd_data_r.ev_value;
      res_nxt.out_seconds      = rd_data_r.seconds;
      res_nxt.out_microseconds = rd_data_r.microseconds;
    end else begin
      case (req_r.kind)
        KIND_REG: begin
          if (free_found) begin
            res_nxt.status          = ST_OK;
            res_nxt.assigned_device = 3'(free_idx);
          end else begin
            res_nxt.status = ST_NO_FREE;
          end
        end
        KIND_INJECT: begin
          if (!dev_ok)     res_nxt.status = ST_BAD_CH;
          else if (q_full) res_nxt.status = ST_FULL;
          else             res_nxt.status = ST_OK;
        end
        KIND_READ: begin
          if (!dev_ok)      res_nxt.status = ST_BAD_CH;
          else if (q_empty) res_nxt.status = ST_EMPTY;
          else              res_nxt.status = ST_OK;
        end
        default: begin
          res_nxt.status = ST_BAD_CH;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec || cmd.rd_done) res_r <= res_nxt;
  end

  assign out_res = res_r;

endmodule

`default_nettype wire

/* tb/tb_multi_queue_event_buffer_top.sv */
// Self-checking testbench for multi_queue_event_buffer_top: directed and random requests,
// results checked against an in-bench model of the per-channel event queues.
// Depends on mqeb_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_multi_queue_event_buffer_top;
  import mqeb_pkg::*;

  localparam int NCH   = 8;
  localparam int DEPTH = 256;

  // kind code the block does not define
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  mqeb_req_t in_req = '0;
  logic      out_valid;
  mqeb_res_t out_res;

  multi_queue_event_buffer_top #(
    .CHANNEL_COUNT(NCH),
    .QUEUE_DEPTH(DEPTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_res(out_res)
  );

  always #5 clk = ~clk;

  // model of the queues
  logic        chan_active [NCH];
  int          wr_ptr [NCH];
  int          rd_ptr [NCH];
  mqeb_entry_t ev_store [NCH*DEPTH];
  logic [31:0] stamp_sec;
  logic [19:0] stamp_usec;

  mqeb_req_t req_backlog [$];
  mqeb_res_t awaited_res [$];
  logic      req_taken = 1'b0;
  int        idle_pct = 0;
  int        err_count = 0;

  function automatic int ring_next(int p);
    return (p + 1 >= DEPTH) ? 0 : p + 1;
  endfunction

  function automatic mqeb_res_t queue_op_result(mqeb_req_t r);
    mqeb_res_t res;
    logic      found;
    int        slot;
    int        nxt;
    res = '0;
    found = 1'b0;
    if (r.kind == KIND_REG) begin
      res.status = ST_NO_FREE;
      for (int i = 0; i < NCH; i++) begin
        if (!found && !chan_active[i]) begin
          found = 1'b1;
          chan_active[i] = 1'b1;
          wr_ptr[i] = 0;
          rd_ptr[i] = 0;
          res.status = ST_OK;
          res.assigned_device = 3'(i);
        end
      end
    end else if ((r.kind != KIND_INJECT && r.kind != KIND_READ) ||
                 int'(r.device) >= NCH || !chan_active[r.device]) begin
      res.status = ST_BAD_CH;
    end else if (r.kind == KIND_INJECT) begin
      nxt = ring_next(wr_ptr[r.device]);
      if (nxt == rd_ptr[r.device]) begin
        res.status = ST_FULL;
      end else begin
        stamp_usec = stamp_usec + USEC_STEP;
        if (stamp_usec >= USEC_PER_SEC) begin
          stamp_usec = stamp_usec - USEC_PER_SEC;
          stamp_sec = stamp_sec + 32'd1;
        end
        slot = int'(r.device) * DEPTH + wr_ptr[r.device];
        ev_store[slot].ev_type = r.event_type;
        ev_store[slot].ev_code = r.event_code;
        ev_store[slot].ev_value = r.event_value;
        ev_store[slot].seconds = stamp_sec;
        ev_store[slot].microseconds = stamp_usec;
        wr_ptr[r.device] = nxt;
        res.status = ST_OK;
      end
    end else begin
      if (rd_ptr[r.device] == wr_ptr[r.device]) begin
        res.status = ST_EMPTY;
      end else begin
        slot = int'(r.device) * DEPTH + rd_ptr[r.device];
        res.status = ST_OK;
        res.out_type = ev_store[slot].ev_type;
        res.out_code = ev_store[slot].ev_code;
        res.out_value = ev_store[slot].ev_value;
        res.out_seconds = ev_store[slot].seconds;
        res.out_microseconds = ev_store[slot].microseconds;
        rd_ptr[r.device] = ring_next(rd_ptr[r.device]);
      end
    end
    return res;
  endfunction

  function automatic mqeb_req_t make_req(logic [1:0] kind, logic [2:0] dev, logic [15:0] typ,
                                         logic [15:0] code, logic [31:0] val);
    mqeb_req_t r;
    r.kind = kind;
    r.device = dev;
    r.event_type = typ;
    r.event_code = code;
    r.event_value = val;
    return r;
  endfunction

  function automatic mqeb_req_t rand_req(logic [1:0] kind, logic [2:0] dev);
    return make_req(kind, dev, 16'($urandom), 16'($urandom), $urandom);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endtask

  // driver: a request is held until the edge that takes it
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !req_taken) begin
      start <= 1'b1;
    end else if (req_backlog.size() != 0 &&
                 !(idle_pct != 0 && $urandom_range(0, 99) < idle_pct)) begin
      start <= 1'b1;
      in_req <= req_backlog.pop_front();
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: check results, predict each accepted request
  always @(posedge clk) begin
    mqeb_res_t want;
    req_taken <= rst_n && start && !busy;
    if (rst_n) begin
      if (out_valid) begin
        if (awaited_res.size() == 0) begin
          $error("result with no request outstanding: %0h", out_res);
          err_count++;
        end else begin
          want = awaited_res.pop_front();
          check_field("status", 32'(want.status), 32'(out_res.status));
          check_field("assigned_device", 32'(want.assigned_device),
                      32'(out_res.assigned_device));
          check_field("out_type", 32'(want.out_type), 32'(out_res.out_type));
          check_field("out_code", 32'(want.out_code), 32'(out_res.out_code));
          check_field("out_value", want.out_value, out_res.out_value);
          check_field("out_seconds", want.out_seconds, out_res.out_seconds);
          check_field("out_microseconds", 32'(want.out_microseconds),
                      32'(out_res.out_microseconds));
        end
      end
      if (start && !busy) awaited_res.push_back(queue_op_result(in_req));
    end
  end

  task automatic drain_backlog();
    while (req_backlog.size() != 0 || start || awaited_res.size() != 0) @(posedge clk);
  endtask

  task automatic push_random_mix(int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 4) req_backlog.push_back(rand_req(KIND_REG, 3'($urandom)));
      else if (r < 8) req_backlog.push_back(rand_req(KIND_UNKNOWN, 3'($urandom)));
      else if (r < 55) req_backlog.push_back(rand_req(KIND_INJECT, 3'($urandom)));
      else req_backlog.push_back(rand_req(KIND_READ, 3'($urandom)));
    end
  endtask

  initial begin
    logic [2:0] fill_ch;
    int         waited;
    for (int i = 0; i < NCH; i++) begin
      chan_active[i] = 1'b0;
      wr_ptr[i] = 0;
      rd_ptr[i] = 0;
    end
    stamp_sec = '0;
    stamp_usec = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: inactive channels, unknown kind, empty, extremes, no free channel
    idle_pct = 0;
    req_backlog.push_back(rand_req(KIND_INJECT, 3'd3));
    req_backlog.push_back(rand_req(KIND_READ, 3'd0));
    req_backlog.push_back(make_req(KIND_UNKNOWN, 3'd0, 16'h0, 16'h0, 32'h0));
    req_backlog.push_back(rand_req(KIND_REG, 3'd5));
    req_backlog.push_back(rand_req(KIND_READ, 3'd0));
    req_backlog.push_back(make_req(KIND_INJECT, 3'd0, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF));
    req_backlog.push_back(make_req(KIND_INJECT, 3'd0, 16'h0000, 16'hFFFF, 32'h0));
    req_backlog.push_back(rand_req(KIND_READ, 3'd0));
    req_backlog.push_back(rand_req(KIND_READ, 3'd0));
    req_backlog.push_back(rand_req(KIND_READ, 3'd0));
    req_backlog.push_back(make_req(KIND_UNKNOWN, 3'd7, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    for (int i = 1; i < NCH; i++) req_backlog.push_back(rand_req(KIND_REG, 3'($urandom)));
    req_backlog.push_back(rand_req(KIND_REG, 3'd0));
    req_backlog.push_back(make_req(KIND_INJECT, 3'd7, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    req_backlog.push_back(make_req(KIND_INJECT, 3'd7, 16'd3, 16'd0, 32'h8000_0001));
    req_backlog.push_back(rand_req(KIND_READ, 3'd7));
    req_backlog.push_back(rand_req(KIND_READ, 3'd7));
    drain_backlog();

    // random, no sender gaps
    push_random_mix(100);
    drain_backlog();

    // random, sender mostly idle
    idle_pct = 68;
    push_random_mix(100);
    drain_backlog();

    // fill one channel past full across the pointer wrap, then drain past empty
    idle_pct = 0;
    fill_ch = 3'($urandom);
    for (int n = 0; n < DEPTH + 2; n++) req_backlog.push_back(rand_req(KIND_INJECT, fill_ch));
    for (int n = 0; n < DEPTH + 1; n++) req_backlog.push_back(rand_req(KIND_READ, fill_ch));
    push_random_mix(100);
    drain_backlog();

    // random, light sender gaps
    idle_pct = 25;
    push_random_mix(100);
    while (req_backlog.size() != 0 || start) @(posedge clk);

    waited = 0;
    while (awaited_res.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (awaited_res.size() != 0) begin
      $error("%0d results never arrived", awaited_res.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
